@@ rtl/core/cpu_execute_stage_regfile_core_assert.svh @@
// Assertion macros shared by the execute stage RTL.
// Each macro expects the including module to have clk and arst_n in scope.
`ifndef CPU_EXECUTE_STAGE_REGFILE_CORE_ASSERT_SVH
`define CPU_EXECUTE_STAGE_REGFILE_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CESR_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cesr: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define CESR_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cesr: next-cycle check failed");

`endif

@@ rtl/core/cesr_pkg.sv @@
// Package for the execute stage with register file.
// Holds operation codes, write target codes, operand source codes and constants.
`timescale 1ns / 1ps
`default_nettype none

package cesr_pkg;

	localparam int DATA_W       = 32;
	localparam int FIELD_IDX_W  = 5;
	localparam int REG_COUNT_D  = 32;
	localparam int VEC_COUNT_D  = 16;
	localparam int LUI_SHIFT    = 16;

	localparam logic [FIELD_IDX_W-1:0] PC_IDX  = FIELD_IDX_W'(1);
	localparam logic [DATA_W-1:0]      PC_STEP = DATA_W'(4);

	// Operation codes carried on the mode field.
	typedef enum logic [4:0] {
		OP_ADD  = 5'd0,
		OP_SUB  = 5'd1,
		OP_SHL  = 5'd2,
		OP_SHR  = 5'd3,
		OP_AND  = 5'd4,
		OP_OR   = 5'd5,
		OP_NOT  = 5'd6,
		OP_XOR  = 5'd7,
		OP_BR   = 5'd8,
		OP_BEQ  = 5'd9,
		OP_BLT  = 5'd10,
		OP_BLE  = 5'd11,
		OP_BGT  = 5'd12,
		OP_BGE  = 5'd13,
		OP_CMP  = 5'd14,
		OP_IRET = 5'd15,
		OP_LB   = 5'd16,
		OP_LW   = 5'd17,
		OP_SB   = 5'd18,
		OP_SW   = 5'd19,
		OP_LUI  = 5'd20,
		OP_CIF  = 5'd21,
		OP_SIF  = 5'd22,
		OP_SETI = 5'd23,
		OP_GETI = 5'd24,
		OP_CSF  = 5'd25
	} op_t;

	// Where a result was written.
	typedef enum logic [1:0] {
		TGT_NONE = 2'd0,
		TGT_REG  = 2'd1,
		TGT_VEC  = 2'd2
	} tgt_t;

	// Where an operand comes from once the read data is registered.
	typedef enum logic [1:0] {
		RS_ZERO = 2'd0,
		RS_MEM  = 2'd1,
		RS_FWD  = 2'd2,
		RS_PC   = 2'd3
	} rsel_t;

endpackage

`default_nettype wire

@@ rtl/core/cpu_execute_stage_regfile_core.sv @@
// Execute stage with a register file and flags: top level.
// Depends on cesr_pkg and cpu_execute_stage_regfile_core_assert.svh.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one decoded instruction per
//   transfer: mode, imm_form, dst_index, src1_index, src2_index, immediate.
//   Output channel (out_valid/out_ready) carries one result per instruction:
//   the PC after it, the branch flag, the write report and the three flags.
//   At the transfer edge the register file is read into the stage 1
//   registers; stage 1 executes and commits at the edge that moves it into
//   the output register, which shows its result. Throughput is one instruction
//   per cycle while out_ready is high; a write made by the instruction in
//   stage 1 is forwarded to the read of the instruction entering behind it.
//   Register 1 (PC) and the flags live in flip-flops; the other registers sit
//   in two copies of a register array (two read ports plus one for LUI).
//   Reset clears the PC, the flags and a valid bit per register, so every
//   register reads as zero at once; no clearing pass is needed.
//   With out_ready low and a full output register, it and stage 1 hold,
//   and in_ready drops once stage 1 is full; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module cpu_execute_stage_regfile_core
	import cesr_pkg::*;
#(
	parameter int REG_COUNT    = REG_COUNT_D,
	parameter int VECTOR_COUNT = VEC_COUNT_D
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic [4:0]               mode,
	input  wire logic                     imm_form,
	input  wire logic [FIELD_IDX_W-1:0]   dst_index,
	input  wire logic [FIELD_IDX_W-1:0]   src1_index,
	input  wire logic [FIELD_IDX_W-1:0]   src2_index,
	input  wire logic signed [DATA_W-1:0] immediate,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic [DATA_W-1:0]             pc_after,
	output logic                          branch_taken,
	output logic [1:0]                    write_target,
	output logic [FIELD_IDX_W-1:0]        written_index,
	output logic [DATA_W-1:0]             written_value,
	output logic                          zero_flag,
	output logic                          negative_flag,
	output logic                          interrupt_enable
);

	localparam int IDX_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

	// Register array copies, valid bits and architectural state.
	logic [DATA_W-1:0]    bank_a [REG_COUNT];
	logic [DATA_W-1:0]    bank_b [REG_COUNT];
	logic [REG_COUNT-1:0] reg_valid_q;
	logic [DATA_W-1:0]    pc_q;
	logic                 zero_q;
	logic                 neg_q;
	logic                 ie_q;
	logic [DATA_W-1:0]    wb_val_q;

	// Stage 1 registers.
	logic              valid_s1;
	op_t               mode_s1;
	logic              imm_s1;
	logic [FIELD_IDX_W-1:0] dst_s1;
	logic [DATA_W-1:0] immediate_s1;
	rsel_t             sel1_s1;
	rsel_t             sel2_s1;
	rsel_t             seld_s1;
	logic [DATA_W-1:0] rd1_s1;
	logic [DATA_W-1:0] rd2_s1;
	logic [DATA_W-1:0] rdd_s1;

	// Output register.
	logic              out_valid_q;
	logic [DATA_W-1:0] pc_after_q;
	logic              taken_q;
	tgt_t              tgt_q;
	logic [FIELD_IDX_W-1:0] widx_q;
	logic [DATA_W-1:0] wval_q;
	logic              zero_out_q;
	logic              neg_out_q;
	logic              ie_out_q;

	// Handshake and write port.
	logic              in_xfer;
	logic              s1_adv;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	rsel_t             sel1_d;
	rsel_t             sel2_d;
	rsel_t             seld_d;

	// Execute results.
	logic [DATA_W-1:0] op1;
	logic [DATA_W-1:0] op2;
	logic [DATA_W-1:0] dval;
	logic [DATA_W-1:0] res;
	logic [DATA_W-1:0] pc_base;
	logic [DATA_W-1:0] pc_next;
	logic              want_reg;
	logic              cond;
	logic              is_branch;
	logic              taken;
	logic              reg_we;
	logic              dst_is_pc;
	logic              zero_next;
	logic              neg_next;
	logic              ie_next;
	logic [DATA_W-1:0] diff;
	tgt_t              tgt_next;
	logic [FIELD_IDX_W-1:0] widx_next;
	logic [DATA_W-1:0] wval_next;

	function automatic logic in_range(input logic [FIELD_IDX_W-1:0] idx);
		return int'(idx) < REG_COUNT;
	endfunction

	function automatic logic [IDX_W-1:0] to_addr(input logic [FIELD_IDX_W-1:0] idx);
		return IDX_W'(idx);
	endfunction

	// Decide where a register read will take its value from.
	function automatic rsel_t pick_src(
		input logic [FIELD_IDX_W-1:0] idx,
		input logic                   we,
		input logic [IDX_W-1:0]       waddr,
		input logic [REG_COUNT-1:0]   vld
	);
		rsel_t sel;
		if (idx == PC_IDX) begin
			sel = RS_PC;
		end else if (!in_range(idx)) begin
			sel = RS_ZERO;
		end else if (we && (waddr == to_addr(idx))) begin
			sel = RS_FWD;
		end else if (vld[to_addr(idx)]) begin
			sel = RS_MEM;
		end else begin
			sel = RS_ZERO;
		end
		return sel;
	endfunction

	function automatic logic [DATA_W-1:0] src_val(
		input rsel_t             sel,
		input logic [DATA_W-1:0] mem_val,
		input logic [DATA_W-1:0] fwd_val,
		input logic [DATA_W-1:0] pc_val
	);
		logic [DATA_W-1:0] v;
		case (sel)
			RS_MEM:  v = mem_val;
			RS_FWD:  v = fwd_val;
			RS_PC:   v = pc_val;
			default: v = '0;
		endcase
		return v;
	endfunction

	// Handshake: stage 1 advances when the output register is free or drains.
	assign s1_adv   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || s1_adv;
	assign in_xfer  = in_valid && in_ready;

	// Operand source selection for the instruction being transferred in.
	always_comb begin
		sel1_d = pick_src(src1_index, wr_en, wr_addr, reg_valid_q);
		sel2_d = pick_src(src2_index, wr_en, wr_addr, reg_valid_q);
		seld_d = pick_src(dst_index, wr_en, wr_addr, reg_valid_q);
	end

	// Execute the instruction held in stage 1.
	always_comb begin
		op1  = src_val(sel1_s1, rd1_s1, wb_val_q, pc_q);
		op2  = imm_s1 ? immediate_s1 : src_val(sel2_s1, rd2_s1, wb_val_q, pc_q);
		dval = src_val(seld_s1, rdd_s1, wb_val_q, pc_q);
		diff = op1 - op2;
		res       = '0;
		want_reg  = 1'b0;
		cond      = 1'b0;
		is_branch = 1'b0;
		zero_next = zero_q;
		neg_next  = neg_q;
		ie_next   = ie_q;
		tgt_next  = TGT_NONE;
		widx_next = '0;
		wval_next = '0;
		case (mode_s1)
			OP_ADD: begin res = op1 + op2; want_reg = 1'b1; end
			OP_SUB: begin res = diff; want_reg = 1'b1; end
			OP_SHL: begin res = op1 << op2[4:0]; want_reg = 1'b1; end
			OP_SHR: begin res = op1 >> op2[4:0]; want_reg = 1'b1; end
			OP_AND: begin res = op1 & op2; want_reg = 1'b1; end
			OP_OR:  begin res = op1 | op2; want_reg = 1'b1; end
			OP_NOT: begin res = ~op2; want_reg = 1'b1; end
			OP_XOR: begin res = op1 ^ op2; want_reg = 1'b1; end
			OP_BR:  begin is_branch = 1'b1; cond = 1'b1; end
			OP_BEQ: begin is_branch = 1'b1; cond = zero_q && !neg_q; end
			OP_BLT: begin is_branch = 1'b1; cond = !zero_q && neg_q; end
			OP_BLE: begin is_branch = 1'b1; cond = zero_q || neg_q; end
			OP_BGT: begin is_branch = 1'b1; cond = !zero_q && !neg_q; end
			OP_BGE: begin is_branch = 1'b1; cond = zero_q || !neg_q; end
			OP_CMP: begin
				zero_next = (diff == '0);
				neg_next  = diff[DATA_W-1];
			end
			OP_LUI: begin res = dval | (op2 << LUI_SHIFT); want_reg = 1'b1; end
			OP_CIF: ie_next = 1'b0;
			OP_SIF: ie_next = 1'b1;
			OP_SETI: begin
				// Vector writes are range checked and reported on the result port.
				if (int'(dst_s1) < VECTOR_COUNT) begin
					tgt_next  = TGT_VEC;
					widx_next = dst_s1;
					wval_next = op1 + op2;
				end
			end
			default: ;
		endcase
		taken = is_branch && cond;
		if (taken) begin
			res      = op1 + {op2[DATA_W-3:0], 2'b00};
			want_reg = 1'b1;
		end
		reg_we    = want_reg && in_range(dst_s1);
		dst_is_pc = (dst_s1 == PC_IDX);
		if (reg_we) begin
			tgt_next  = TGT_REG;
			widx_next = dst_s1;
			wval_next = res;
		end
		// A taken branch leaves the PC alone unless it targets register 1.
		pc_base = (reg_we && dst_is_pc) ? res : pc_q;
		pc_next = taken ? pc_base : pc_base + PC_STEP;
	end

	assign wr_en   = s1_adv && reg_we && !dst_is_pc;
	assign wr_addr = to_addr(dst_s1);

	// Register array: one write port, registered reads at transfer.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			bank_a[wr_addr] <= res;
			bank_b[wr_addr] <= res;
		end
		if (in_xfer) begin
			rd1_s1 <= bank_a[to_addr(src1_index)];
			rd2_s1 <= bank_a[to_addr(src2_index)];
			rdd_s1 <= bank_b[to_addr(dst_index)];
		end
	end

	// Last written value, used by the forwarding path.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			wb_val_q <= res;
		end
	end

	// Stage 1 payload.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			mode_s1      <= op_t'(mode);
			imm_s1       <= imm_form;
			dst_s1       <= dst_index;
			immediate_s1 <= immediate;
			sel1_s1      <= sel1_d;
			sel2_s1      <= sel2_d;
			seld_s1      <= seld_d;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			pc_after_q <= pc_next;
			taken_q    <= taken;
			tgt_q      <= tgt_next;
			widx_q     <= widx_next;
			wval_q     <= wval_next;
			zero_out_q <= zero_next;
			neg_out_q  <= neg_next;
			ie_out_q   <= ie_next;
		end
	end

	// Control state, PC, flags and register valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			pc_q        <= '0;
			zero_q      <= 1'b0;
			neg_q       <= 1'b0;
			ie_q        <= 1'b0;
			reg_valid_q <= '0;
		end else begin
			if (in_xfer) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
				pc_q        <= pc_next;
				zero_q      <= zero_next;
				neg_q       <= neg_next;
				ie_q        <= ie_next;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (wr_en) begin
				reg_valid_q[wr_addr] <= 1'b1;
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign pc_after         = pc_after_q;
	assign branch_taken     = taken_q;
	assign write_target     = tgt_q;
	assign written_index    = widx_q;
	assign written_value    = wval_q;
	assign zero_flag        = zero_out_q;
	assign negative_flag    = neg_out_q;
	assign interrupt_enable = ie_out_q;

	// Checks on the execute and commit logic.
`include "cpu_execute_stage_regfile_core_assert.svh"

	`CESR_ASSERT_IMP(a_no_write_zero, out_valid_q && (tgt_q == TGT_NONE), (widx_q == '0) && (wval_q == '0))
	`CESR_ASSERT_IMP(a_branch_not_vec, out_valid_q && taken_q, tgt_q != TGT_VEC)
	`CESR_ASSERT_NXT(a_pc_step, s1_adv && !taken && !(reg_we && dst_is_pc), pc_q == ($past(pc_q) + PC_STEP))
	`CESR_ASSERT_NXT(a_s1_hold, valid_s1 && !s1_adv, valid_s1 && $stable(dst_s1) && $stable(mode_s1))
	`CESR_ASSERT_IMP(a_no_pc_in_bank, wr_en, !dst_is_pc)

endmodule

`default_nettype wire
